>>> rtl/lob_pkg.sv
// Shared types, widths and codes for the limit order book matcher.
// Used by every module of the block; depends on nothing else.
package lob_pkg;

    localparam int BOOK_DEPTH = 256;
    localparam int PRICE_W    = 32;
    localparam int ID_W       = 32;
    localparam int QTY_W      = 32;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = IDX_W + 1;
    localparam int SPREAD_W   = PRICE_W + 1;
    localparam int TRADE_W    = 10;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [TRADE_W-1:0] TRADE_MAX = {TRADE_W{1'b1}};

    localparam int IN_BITS    = ID_W + 1 + PRICE_W + QTY_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * PRICE_W + SPREAD_W + TRADE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_MATCH  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_QTY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
    } t_entry;

    // One classified command as it waits in the queue.
    typedef struct packed {
        t_cmd_code          kind;
        logic               qty_zero;
        logic               sell;
        t_entry             ord;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [PRICE_W-1:0]    best_bid;
        logic [PRICE_W-1:0]    best_ask;
        logic [SPREAD_W-1:0]   spread;
        logic [TRADE_W-1:0]    trade_count;
    } t_result;

endpackage

>>> rtl/lob_front.sv
// Front end: accepts command items, classifies them and holds them in a
// two-entry queue for the book engine. Depends on lob_pkg.
module lob_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lob_pkg::IN_DATA_W-1:0] i_data,
    input  logic [lob_pkg::CMD_W-1:0]    i_user,
    output logic                         o_q_valid,
    output lob_pkg::t_cmd                o_q_item,
    input  logic                         i_pop
);

    lob_pkg::t_cmd r_q [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    lob_pkg::t_cmd cls;
    logic          push;

    always_comb begin
        cls.ord.id    = i_data[lob_pkg::ID_W-1:0];
        cls.sell      = i_data[lob_pkg::ID_W];
        cls.ord.price = i_data[lob_pkg::ID_W+1 +: lob_pkg::PRICE_W];
        cls.ord.qty   = i_data[lob_pkg::ID_W+1+lob_pkg::PRICE_W +: lob_pkg::QTY_W];
        cls.qty_zero  = (cls.ord.qty == '0);
        unique case (i_user)
            lob_pkg::CMD_ADD:    cls.kind = lob_pkg::CMD_ADD;
            lob_pkg::CMD_CANCEL: cls.kind = lob_pkg::CMD_CANCEL;
            lob_pkg::CMD_MATCH:  cls.kind = lob_pkg::CMD_MATCH;
            default:             cls.kind = lob_pkg::CMD_NOP;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> rtl/lob_engine.sv
// Back end: holds both sorted books in one memory and carries out add,
// cancel and match commands step by step. Depends on lob_pkg.
module lob_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  lob_pkg::t_cmd    i_q_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output lob_pkg::t_result o_result
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_INS_R = 14'b00000000000010,
        S_INS_W = 14'b00000000000100,
        S_DEL_R = 14'b00000000001000,
        S_DEL_W = 14'b00000000010000,
        S_CAN_R = 14'b00000000100000,
        S_CAN_W = 14'b00000001000000,
        S_M_RB  = 14'b00000010000000,
        S_M_RA  = 14'b00000100000000,
        S_M_EX  = 14'b00001000000000,
        S_NEXT  = 14'b00010000000000,
        S_H_RB  = 14'b00100000000000,
        S_H_RA  = 14'b01000000000000,
        S_H_OUT = 14'b10000000000000
    } t_state;

    typedef enum logic [3:0] {
        PH_DELA = 4'b0001,
        PH_INSB = 4'b0010,
        PH_INSA = 4'b0100,
        PH_LOOP = 4'b1000
    } t_phase;

    // Bid book in the lower half, ask book in the upper half.
    lob_pkg::t_entry mem [0:2*lob_pkg::BOOK_DEPTH-1];
    lob_pkg::t_entry r_rd;

    t_state                       r_st, n_st;
    t_phase                       r_ph, n_ph;
    logic                         r_sd, n_sd;
    logic [lob_pkg::CNT_W-1:0]    r_i, n_i;
    logic [lob_pkg::CNT_W-1:0]    r_cnt_b, n_cnt_b;
    logic [lob_pkg::CNT_W-1:0]    r_cnt_a, n_cnt_a;
    lob_pkg::t_entry              r_new, n_new;
    lob_pkg::t_entry              r_hb, n_hb;
    lob_pkg::t_entry              r_ha, n_ha;
    logic                         r_is_match, n_is_match;
    lob_pkg::t_status             r_status, n_status;
    logic [lob_pkg::TRADE_W-1:0]  r_trades, n_trades;
    logic [lob_pkg::PRICE_W-1:0]  r_bb, n_bb;
    logic                         r_ov, n_ov;
    lob_pkg::t_result             r_res, n_res;

    logic                         rd_en, we;
    logic [lob_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
    lob_pkg::t_entry              wr_data;
    logic [lob_pkg::CNT_W-1:0]    cnt_sel, i_inc, i_dec;
    logic                         keeps;
    logic [lob_pkg::PRICE_W-1:0]  ba;

    assign cnt_sel = r_sd ? r_cnt_a : r_cnt_b;
    assign i_inc   = r_i + 1'b1;
    assign i_dec   = r_i - 1'b1;
    // An entry that ranks at least as well as the new order stays ahead of it.
    assign keeps   = r_sd ? (r_rd.price <= r_new.price) : (r_rd.price >= r_new.price);
    assign ba      = (r_cnt_a != '0) ? r_rd.price : '0;

    assign o_valid  = r_ov;
    assign o_result = r_res;
    assign o_pop    = (r_st == S_IDLE) && i_q_valid;

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_sd = r_sd; n_i = r_i;
        n_cnt_b = r_cnt_b; n_cnt_a = r_cnt_a;
        n_new = r_new; n_hb = r_hb; n_ha = r_ha;
        n_is_match = r_is_match; n_status = r_status; n_trades = r_trades;
        n_bb = r_bb; n_res = r_res;
        n_ov = r_ov && !i_ready;
        rd_en = 1'b0; rd_addr = '0;
        we = 1'b0; wr_addr = '0; wr_data = r_new;

        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_new      = i_q_item.ord;
                    n_status   = lob_pkg::ST_OK;
                    n_trades   = '0;
                    n_is_match = (i_q_item.kind == lob_pkg::CMD_MATCH);
                    n_sd       = 1'b0;
                    n_i        = '0;
                    unique case (i_q_item.kind)
                        lob_pkg::CMD_ADD: begin
                            n_sd = i_q_item.sell;
                            if (i_q_item.qty_zero) begin
                                n_status = lob_pkg::ST_ZERO_QTY;
                                n_st     = S_H_RB;
                            end else if ((i_q_item.sell ? r_cnt_a : r_cnt_b) >=
                                         lob_pkg::CNT_W'(lob_pkg::BOOK_DEPTH)) begin
                                n_status = lob_pkg::ST_FULL;
                                n_st     = S_H_RB;
                            end else begin
                                n_i  = i_q_item.sell ? r_cnt_a : r_cnt_b;
                                n_st = S_INS_R;
                            end
                        end
                        lob_pkg::CMD_CANCEL: n_st = S_CAN_R;
                        lob_pkg::CMD_MATCH:  n_st = S_M_RB;
                        default:             n_st = S_H_RB;
                    endcase
                end
            end
            S_INS_R: begin
                if (r_i == '0) begin
                    we      = 1'b1;
                    wr_addr = {r_sd, {lob_pkg::IDX_W{1'b0}}};
                    wr_data = r_new;
                    if (r_sd) n_cnt_a = r_cnt_a + 1'b1;
                    else      n_cnt_b = r_cnt_b + 1'b1;
                    n_st = S_NEXT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = {r_sd, i_dec[lob_pkg::IDX_W-1:0]};
                    n_st    = S_INS_W;
                end
            end
            S_INS_W: begin
                we      = 1'b1;
                wr_addr = {r_sd, r_i[lob_pkg::IDX_W-1:0]};
                if (keeps) begin
                    wr_data = r_new;
                    if (r_sd) n_cnt_a = r_cnt_a + 1'b1;
                    else      n_cnt_b = r_cnt_b + 1'b1;
                    n_st = S_NEXT;
                end else begin
                    wr_data = r_rd;
                    n_i     = i_dec;
                    n_st    = S_INS_R;
                end
            end
            S_DEL_R: begin
                if (i_inc < cnt_sel) begin
                    rd_en   = 1'b1;
                    rd_addr = {r_sd, i_inc[lob_pkg::IDX_W-1:0]};
                    n_st    = S_DEL_W;
                end else begin
                    if (r_sd) n_cnt_a = r_cnt_a - 1'b1;
                    else      n_cnt_b = r_cnt_b - 1'b1;
                    n_st = S_NEXT;
                end
            end
            S_DEL_W: begin
                we      = 1'b1;
                wr_addr = {r_sd, r_i[lob_pkg::IDX_W-1:0]};
                wr_data = r_rd;
                n_i     = i_inc;
                n_st    = S_DEL_R;
            end
            S_CAN_R: begin
                if (r_i < cnt_sel) begin
                    rd_en   = 1'b1;
                    rd_addr = {r_sd, r_i[lob_pkg::IDX_W-1:0]};
                    n_st    = S_CAN_W;
                end else if (!r_sd) begin
                    n_sd = 1'b1;
                    n_i  = '0;
                end else begin
                    n_status = lob_pkg::ST_NOT_FOUND;
                    n_st     = S_NEXT;
                end
            end
            S_CAN_W: begin
                if (r_rd.id == r_new.id) begin
                    n_st = S_DEL_R;
                end else begin
                    n_i  = i_inc;
                    n_st = S_CAN_R;
                end
            end
            S_M_RB: begin
                if (r_cnt_b != '0 && r_cnt_a != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_st    = S_M_RA;
                end else begin
                    n_st = S_H_RB;
                end
            end
            S_M_RA: begin
                n_hb    = r_rd;
                rd_en   = 1'b1;
                rd_addr = {1'b1, {lob_pkg::IDX_W{1'b0}}};
                n_st    = S_M_EX;
            end
            S_M_EX: begin
                if (r_hb.price >= r_rd.price) begin
                    n_ha = r_rd;
                    if (r_hb.qty < r_rd.qty) begin
                        n_hb.qty = '0;
                        n_ha.qty = r_rd.qty - r_hb.qty;
                    end else begin
                        n_hb.qty = r_hb.qty - r_rd.qty;
                        n_ha.qty = '0;
                    end
                    if (r_trades != lob_pkg::TRADE_MAX) begin
                        n_trades = r_trades + 1'b1;
                    end
                    n_sd = 1'b0;
                    n_i  = '0;
                    n_ph = PH_DELA;
                    n_st = S_DEL_R;
                end else begin
                    n_st = S_H_RB;
                end
            end
            S_NEXT: begin
                if (!r_is_match) begin
                    n_st = S_H_RB;
                end else begin
                    unique case (r_ph)
                        PH_DELA: begin
                            n_sd = 1'b1;
                            n_i  = '0;
                            n_ph = PH_INSB;
                            n_st = S_DEL_R;
                        end
                        PH_INSB: begin
                            n_ph = PH_INSA;
                            if (r_hb.qty != '0) begin
                                n_sd  = 1'b0;
                                n_new = r_hb;
                                n_i   = r_cnt_b;
                                n_st  = S_INS_R;
                            end
                        end
                        PH_INSA: begin
                            n_ph = PH_LOOP;
                            if (r_ha.qty != '0) begin
                                n_sd  = 1'b1;
                                n_new = r_ha;
                                n_i   = r_cnt_a;
                                n_st  = S_INS_R;
                            end
                        end
                        default: n_st = S_M_RB;
                    endcase
                end
            end
            S_H_RB: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_st    = S_H_RA;
            end
            S_H_RA: begin
                n_bb    = (r_cnt_b != '0) ? r_rd.price : '0;
                rd_en   = 1'b1;
                rd_addr = {1'b1, {lob_pkg::IDX_W{1'b0}}};
                n_st    = S_H_OUT;
            end
            S_H_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov               = 1'b1;
                    n_res.status       = r_status;
                    n_res.best_bid     = r_bb;
                    n_res.best_ask     = ba;
                    n_res.spread       = (r_cnt_b != '0 && r_cnt_a != '0) ?
                                         ({1'b0, ba} - {1'b0, r_bb}) : '0;
                    n_res.trade_count  = r_is_match ? r_trades : '0;
                    n_st               = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_ph    <= PH_DELA;
            r_cnt_b <= '0;
            r_cnt_a <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_ph    <= n_ph;
            r_cnt_b <= n_cnt_b;
            r_cnt_a <= n_cnt_a;
            r_ov    <= n_ov;
        end
        r_sd       <= n_sd;
        r_i        <= n_i;
        r_new      <= n_new;
        r_hb       <= n_hb;
        r_ha       <= n_ha;
        r_is_match <= n_is_match;
        r_status   <= n_status;
        r_trades   <= n_trades;
        r_bb       <= n_bb;
        r_res      <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher: command queue front end and
// book engine back end. Depends on lob_pkg, lob_front and lob_engine.
//
//  channel   | direction | tuser        | tdata
//  s_axis    | in        | cmd          | order_id, is_sell, price_ticks, quantity
//  m_axis    | out       | status       | best_bid, best_ask, spread, trade_count
//
// Each item gives exactly one result item. An add moves every entry behind its
// insert point one place, a cancel scans the bid book and then the ask book for
// the id, and a match deletes both tops and reinserts any remainder per trade.
// The single book memory port (one read, one write a cycle) paces this work.
// Reset is synchronous and empties both books.
// Up to two items wait in the front queue while the engine or the output stalls.
module limit_order_book_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // order_id, is_sell, price_ticks, quantity (from bit 0 up), zero padded
    input  logic [lob_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [lob_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // best_bid, best_ask, spread, trade_count (from bit 0 up), zero padded
    output logic [lob_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [lob_pkg::STATUS_W-1:0]    m_axis_tuser
);

    logic             q_valid;
    logic             q_pop;
    lob_pkg::t_cmd    q_item;
    lob_pkg::t_result res;

    lob_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_pop     (q_pop)
    );

    lob_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {{(lob_pkg::OUT_DATA_W-lob_pkg::OUT_BITS){1'b0}},
                           res.trade_count, res.spread, res.best_ask, res.best_bid};

endmodule

>>> rtl/lob_checker.sv
// Port-level checks for the limit order book matcher, bound to the top level.
// Depends on lob_pkg and limit_order_book_matcher.
module lob_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lob_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [lob_pkg::STATUS_W-1:0]    m_axis_tuser
);

    logic [lob_pkg::PRICE_W-1:0]  bid;
    logic [lob_pkg::PRICE_W-1:0]  ask;
    logic [lob_pkg::SPREAD_W-1:0] spr;
    logic [lob_pkg::TRADE_W-1:0]  trd;

    assign bid = m_axis_tdata[lob_pkg::PRICE_W-1:0];
    assign ask = m_axis_tdata[lob_pkg::PRICE_W +: lob_pkg::PRICE_W];
    assign spr = m_axis_tdata[2*lob_pkg::PRICE_W +: lob_pkg::SPREAD_W];
    assign trd = m_axis_tdata[2*lob_pkg::PRICE_W+lob_pkg::SPREAD_W +: lob_pkg::TRADE_W];

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && spr != '0 |-> spr == ({1'b0, ask} - {1'b0, bid}))
        else $error("spread does not match the top of book");

    // After matching the book is no longer crossed: an empty side gives a zero
    // spread, otherwise the spread is positive.
    a_trade_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && trd != '0 |->
            m_axis_tuser == lob_pkg::ST_OK && !spr[lob_pkg::SPREAD_W-1])
        else $error("book still crossed or bad status after trades");

endmodule

bind limit_order_book_matcher lob_checker u_lob_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
